// ----- rtl/core/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and codes for the open-addressing hash table core: request
// actions, response status codes, slot kinds and the store interface records.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int unsigned SLOTS_DEF = 256;

   localparam int unsigned KEY_W  = 32;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned ACT_W  = 2;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned KIND_W = 2;

   // Request actions.
   localparam logic [ACT_W-1:0] ACT_GET = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SET = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DEL = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   // Slot kinds.
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LIVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOMB  = 2'd2;

   typedef struct packed {
      logic              kind_we;
      logic              entry_we;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } wr_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } rd_data_type;

endpackage

// ----- rtl/core/open_addressing_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Linear-probing hash table with tombstones; get, set and delete requests.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          req_action, req_key_id, req_key_hash, req_data_in
//  response  rsp_valid (strobe)   rsp_status, rsp_data_out, rsp_new_key
//
// After reset the core sweeps the slot store to empty, one slot a cycle, and
// busy stays high through the sweep. A request is taken when start is high and
// busy is low. Requests answered without probing respond in the next cycle.
// Others probe the slots, one per cycle through the store read port, preceded
// by the start-slot reduction (multiply, then modulo) when SLOTS is not a
// power of two. The response is shown for one cycle only.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core #(
   parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [oaht_pkg::ACT_W-1:0]  req_action,
   input  logic [oaht_pkg::KEY_W-1:0]  req_key_id,
   input  logic [oaht_pkg::KEY_W-1:0]  req_key_hash,
   input  logic [oaht_pkg::DATA_W-1:0] req_data_in,
   output logic                        rsp_valid,
   output logic [oaht_pkg::STAT_W-1:0] rsp_status,
   output logic [oaht_pkg::DATA_W-1:0] rsp_data_out,
   output logic                        rsp_new_key
);
   import oaht_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOTS);

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   wr_cmd_type       wr_cmd;
   rd_data_type      rd_data;

   oaht_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_cmd  (wr_cmd),
      .rd_data (rd_data)
   );

   oaht_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_key_id   (req_key_id),
      .req_key_hash (req_key_hash),
      .req_data_in  (req_data_in),
      .rd_data      (rd_data),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .wr_cmd       (wr_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_new_key  (rsp_new_key)
   );

endmodule

// ----- rtl/core/oaht_store.sv -----
// ----------------------------------------------------------------------------
// oaht_store
// Slot storage: kind, key and value memories with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module oaht_store #(
   parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEF,
   localparam int unsigned IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [IDX_W-1:0]     wr_addr,
   input  oaht_pkg::wr_cmd_type wr_cmd,
   output oaht_pkg::rd_data_type rd_data
);
   import oaht_pkg::*;

   logic [KIND_W-1:0] kind_mem [SLOTS];
   logic [KEY_W-1:0]  key_mem  [SLOTS];
   logic [DATA_W-1:0] data_mem [SLOTS];

   rd_data_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.kind_we) begin
         kind_mem[wr_addr] <= wr_cmd.kind;
      end
      if (wr_cmd.entry_we) begin
         key_mem[wr_addr]  <= wr_cmd.key;
         data_mem[wr_addr] <= wr_cmd.data;
      end
      rd_ff.kind <= kind_mem[rd_addr];
      rd_ff.key  <= key_mem[rd_addr];
      rd_ff.data <= data_mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ----- rtl/core/oaht_ctrl.sv -----
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: clearing pass, start-slot reduction, linear probe over
// the slot store one slot per cycle, and the final update and response.
// ----------------------------------------------------------------------------
module oaht_ctrl #(
   parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEF,
   localparam int unsigned IDX_W = $clog2(SLOTS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [oaht_pkg::ACT_W-1:0]     req_action,
   input  logic [oaht_pkg::KEY_W-1:0]     req_key_id,
   input  logic [oaht_pkg::KEY_W-1:0]     req_key_hash,
   input  logic [oaht_pkg::DATA_W-1:0]    req_data_in,
   input  oaht_pkg::rd_data_type          rd_data,
   output logic [IDX_W-1:0]               rd_addr,
   output logic [IDX_W-1:0]               wr_addr,
   output oaht_pkg::wr_cmd_type           wr_cmd,
   output logic                           rsp_valid,
   output logic [oaht_pkg::STAT_W-1:0]    rsp_status,
   output logic [oaht_pkg::DATA_W-1:0]    rsp_data_out,
   output logic                           rsp_new_key
);
   import oaht_pkg::*;

   localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
   localparam int unsigned LIM_W   = CNT_W + 3;
   localparam int unsigned RECIP_W = KEY_W + 1;
   localparam int unsigned PROD_W  = KEY_W + RECIP_W;
   localparam int unsigned SHIFT   = KEY_W + IDX_W;
   localparam int unsigned QUO_W   = PROD_W - SHIFT;
   localparam bit          POW2    = (SLOTS & (SLOTS - 1)) == 0;

   localparam logic [IDX_W-1:0]   LAST  = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]   BOUND = CNT_W'(SLOTS - 1);
   localparam logic [LIM_W-1:0]   LIMIT = LIM_W'(3 * SLOTS);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_MUL    = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  start_idx_ff, start_idx_in;
   logic              have_tomb_ff, have_tomb_in;
   logic [IDX_W-1:0]  tomb_ff, tomb_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [KIND_W-1:0] slot_kind_ff, slot_kind_in;
   logic [DATA_W-1:0] hit_data_ff, hit_data_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  hash_ff, hash_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_new_ff, rsp_new_in;

   logic [QUO_W-1:0]  quot;
   logic [KEY_W-1:0]  rem_val;
   logic [IDX_W-1:0]  req_start;
   logic              full;
   logic              is_empty, is_hit, is_tomb, at_bound, stop;
   logic              tomb_now;
   logic [IDX_W-1:0]  tomb_idx;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] r;
      if (a == LAST) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   // The rounded-up reciprocal gives hash / SLOTS exactly for every 32-bit
   // hash; the remainder then follows from one constant multiply and subtract.
   assign quot    = prod_ff[PROD_W-1:SHIFT];
   assign rem_val = hash_ff - (KEY_W'(quot) * KEY_W'(SLOTS));

   assign req_start = req_key_hash[IDX_W-1:0];
   assign full      = ((LIM_W'(used_ff) + LIM_W'(1)) << 2) > LIMIT;

   assign is_empty = rd_data.kind == KIND_EMPTY;
   assign is_hit   = (rd_data.kind == KIND_LIVE) && (rd_data.key == key_ff);
   assign is_tomb  = rd_data.kind == KIND_TOMB;
   assign at_bound = cnt_ff == BOUND;
   assign stop     = is_empty || is_hit || at_bound;
   assign tomb_now = have_tomb_ff || is_tomb;
   assign tomb_idx = have_tomb_ff ? tomb_ff : chk_idx_ff;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      cnt_in        = cnt_ff;
      start_idx_in  = start_idx_ff;
      have_tomb_in  = have_tomb_ff;
      tomb_in       = tomb_ff;
      slot_in       = slot_ff;
      slot_kind_in  = slot_kind_ff;
      hit_data_in   = hit_data_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      hash_in       = hash_ff;
      data_in       = data_ff;
      prod_in       = prod_ff;
      used_in       = used_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_new_in    = rsp_new_ff;
      rd_addr       = addr_ff;
      wr_addr       = slot_ff;
      wr_cmd        = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_addr       = addr_ff;
            wr_cmd.kind_we = 1'b1;
            wr_cmd.kind    = KIND_EMPTY;
            addr_in       = wrap_inc(addr_ff);
            if (addr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req_start;
            if (start) begin
               act_in       = req_action;
               key_in       = req_key_id;
               hash_in      = req_key_hash;
               data_in      = req_data_in;
               cnt_in       = '0;
               have_tomb_in = 1'b0;
               rsp_data_in  = '0;
               rsp_new_in   = 1'b0;
               if (((req_action == ACT_GET || req_action == ACT_DEL) && used_ff != '0) ||
                   (req_action == ACT_SET && !full)) begin
                  if (POW2) begin
                     // The first slot is read in this very cycle.
                     state_in     = S_PROBE;
                     chk_vld_in   = 1'b1;
                     chk_idx_in   = req_start;
                     start_idx_in = req_start;
                     addr_in      = wrap_inc(req_start);
                  end else begin
                     state_in = S_MUL;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (req_action == ACT_SET) ? STAT_FULL : STAT_MISS;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(hash_ff) * PROD_W'(RECIP);
            state_in = S_MOD;
         end
         S_MOD: begin
            state_in     = S_PROBE;
            addr_in      = rem_val[IDX_W-1:0];
            start_idx_in = rem_val[IDX_W-1:0];
            chk_vld_in   = 1'b0;
         end
         S_PROBE: begin
            // Reads run one slot ahead of the check; the extra read is dropped.
            chk_idx_in = addr_ff;
            addr_in    = wrap_inc(addr_ff);
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (is_tomb && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = chk_idx_ff;
               end
               if (stop) begin
                  state_in    = S_FINISH;
                  chk_vld_in  = 1'b0;
                  hit_data_in = rd_data.data;
                  if (is_hit) begin
                     slot_in      = chk_idx_ff;
                     slot_kind_in = KIND_LIVE;
                  end else if (is_empty) begin
                     slot_in      = have_tomb_ff ? tomb_ff : chk_idx_ff;
                     slot_kind_in = have_tomb_ff ? KIND_TOMB : KIND_EMPTY;
                  end else begin
                     slot_in      = tomb_now ? tomb_idx : start_idx_ff;
                     slot_kind_in = tomb_now ? KIND_TOMB : KIND_EMPTY;
                  end
               end
            end
         end
         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (act_ff)
               ACT_GET: begin
                  if (slot_kind_ff == KIND_LIVE) begin
                     rsp_status_in = STAT_OK;
                     rsp_data_in   = hit_data_ff;
                  end else begin
                     rsp_status_in = STAT_MISS;
                  end
               end
               ACT_SET: begin
                  wr_cmd.kind_we  = 1'b1;
                  wr_cmd.entry_we = 1'b1;
                  wr_cmd.kind     = KIND_LIVE;
                  wr_cmd.key      = key_ff;
                  wr_cmd.data     = data_ff;
                  rsp_status_in   = STAT_OK;
                  rsp_new_in      = slot_kind_ff != KIND_LIVE;
                  if (slot_kind_ff == KIND_EMPTY) begin
                     used_in = used_ff + 1'b1;
                  end
               end
               ACT_DEL: begin
                  if (slot_kind_ff == KIND_LIVE) begin
                     wr_cmd.kind_we = 1'b1;
                     wr_cmd.kind    = KIND_TOMB;
                     rsp_status_in  = STAT_OK;
                  end else begin
                     rsp_status_in = STAT_MISS;
                  end
               end
               default: begin
                  rsp_status_in = STAT_MISS;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         cnt_ff       <= '0;
         have_tomb_ff <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_vld_ff   <= chk_vld_in;
         cnt_ff       <= cnt_in;
         have_tomb_ff <= have_tomb_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      start_idx_ff  <= start_idx_in;
      tomb_ff       <= tomb_in;
      slot_ff       <= slot_in;
      slot_kind_ff  <= slot_kind_in;
      hit_data_ff   <= hit_data_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      data_ff       <= data_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_new_ff    <= rsp_new_in;
   end

   assign busy         = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_new_key  = rsp_new_ff;

endmodule

// ----- rtl/core/oaht_checker.sv -----
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
module oaht_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [oaht_pkg::STAT_W-1:0] rsp_status,
   input logic [oaht_pkg::DATA_W-1:0] rsp_data_out,
   input logic                        rsp_new_key
);
   import oaht_pkg::*;

   // Reset starts the clearing sweep and drops any pending response.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("core not busy or response shown after reset");

   a_miss_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_data_out == '0)
      else $error("data returned with a failing status");

   a_new_key_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_key |-> rsp_status == STAT_OK)
      else $error("new key flagged on a failing response");

   // An insert always goes through a probe, so the core was busy just before.
   a_new_key_probed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_key |-> $past(busy))
      else $error("new key reported without a probe");

endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (.*);

// ----- tb/tb_open_addressing_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_table_core
// Self-checking bench for the linear-probing hash table core. A shadow copy
// of the slot store predicts the response to every accepted request. A
// monitor compares each strobed response with the oldest prediction.
// Stimulus starts with a directed run over the empty table, wrap-round
// probing and tombstone reuse. Random requests on a clustered key pool
// follow, under three sender idling profiles. Last, the table is filled to
// its load limit so that sets are refused.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   import oaht_pkg::*;

   localparam int unsigned SLOTS        = SLOTS_DEF;
   localparam int unsigned KEY_POOL     = 48;
   localparam int unsigned DRAIN_CYCLES = SLOTS + 40;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;

   // Action code that the core does not define; it must answer as a miss.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] data_out;
      logic              new_key;
   } rsp_fields_type;

   class shadow_table;
      logic [KIND_W-1:0] kind [SLOTS];
      logic [KEY_W-1:0]  key  [SLOTS];
      logic [DATA_W-1:0] data [SLOTS];
      int unsigned       used;
      int unsigned       errors;
      rsp_fields_type    awaited [$];

      function new();
         foreach (kind[i]) begin
            kind[i] = KIND_EMPTY;
         end
         used   = 0;
         errors = 0;
      endfunction

      // Slot holding the key, or the slot where a set would place it.
      function int unsigned find_slot(logic [KEY_W-1:0] k, logic [KEY_W-1:0] h);
         int unsigned idx;
         int unsigned first;
         int unsigned tomb;
         bit          have_tomb;
         idx       = h % SLOTS;
         first     = idx;
         tomb      = 0;
         have_tomb = 0;
         for (int n = 0; n < SLOTS; n++) begin
            if (kind[idx] == KIND_EMPTY) begin
               return have_tomb ? tomb : idx;
            end
            if (kind[idx] == KIND_LIVE) begin
               if (key[idx] == k) begin
                  return idx;
               end
            end else if (!have_tomb) begin
               tomb      = idx;
               have_tomb = 1;
            end
            idx = (idx + 1) % SLOTS;
         end
         return have_tomb ? tomb : first;
      endfunction

      function void take_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                 logic [KEY_W-1:0] h, logic [DATA_W-1:0] d);
         rsp_fields_type r;
         int unsigned s;
         r.status   = STAT_MISS;
         r.data_out = '0;
         r.new_key  = 1'b0;
         case (act)
            ACT_GET: begin
               if (used != 0) begin
                  s = find_slot(k, h);
                  if (kind[s] == KIND_LIVE) begin
                     r.status   = STAT_OK;
                     r.data_out = data[s];
                  end
               end
            end
            ACT_SET: begin
               // The load check comes before probing, so updates are refused too.
               if (4 * (used + 1) > 3 * SLOTS) begin
                  r.status = STAT_FULL;
               end else begin
                  s = find_slot(k, h);
                  if (kind[s] != KIND_LIVE) begin
                     r.new_key = 1'b1;
                     if (kind[s] == KIND_EMPTY) begin
                        used++;
                     end
                  end
                  kind[s]  = KIND_LIVE;
                  key[s]   = k;
                  data[s]  = d;
                  r.status = STAT_OK;
               end
            end
            ACT_DEL: begin
               if (used != 0) begin
                  s = find_slot(k, h);
                  if (kind[s] == KIND_LIVE) begin
                     kind[s]  = KIND_TOMB;
                     r.status = STAT_OK;
                  end
               end
            end
            default: begin
            end
         endcase
         awaited.push_back(r);
      endfunction

      function void check_response(logic [STAT_W-1:0] st, logic [DATA_W-1:0] dout,
                                   logic nk);
         rsp_fields_type e;
         if (awaited.size() == 0) begin
            $error("response with no request outstanding: status %0d data_out %h",
                   st, dout);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
         if (dout !== e.data_out) begin
            $error("data_out: expected %h, got %h", e.data_out, dout);
            errors++;
         end
         if (nk !== e.new_key) begin
            $error("new_key: expected %0d, got %0d", e.new_key, nk);
            errors++;
         end
      endfunction
   endclass

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              start        = 1'b0;
   logic              busy;
   logic [ACT_W-1:0]  req_action   = ACT_GET;
   logic [KEY_W-1:0]  req_key_id   = '0;
   logic [KEY_W-1:0]  req_key_hash = '0;
   logic [DATA_W-1:0] req_data_in  = '0;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_data_out;
   logic              rsp_new_key;

   shadow_table       shadow = new();
   logic [KEY_W-1:0]  pool_key  [KEY_POOL];
   logic [KEY_W-1:0]  pool_hash [KEY_POOL];
   int unsigned       cycle_count = 0;

   open_addressing_hash_table_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_key_id   (req_key_id),
      .req_key_hash (req_key_hash),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_new_key  (rsp_new_key)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         shadow.check_response(rsp_status, rsp_data_out, rsp_new_key);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Start is left high after acceptance so that back-to-back requests do not
   // lower and raise it within one time step.
   task automatic send_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                               logic [KEY_W-1:0] h, logic [DATA_W-1:0] d,
                               int unsigned idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_key_id   <= k;
      req_key_hash <= h;
      req_data_in  <= d;
      do @(posedge clock); while (busy);
      shadow.take_request(act, k, h, d);
   endtask

   task automatic random_request(int unsigned idle_pct);
      int unsigned      pick;
      int unsigned      entry;
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] h;
      pick = $urandom_range(99);
      if (pick < 36) begin
         act = ACT_GET;
      end else if (pick < 72) begin
         act = ACT_SET;
      end else if (pick < 95) begin
         act = ACT_DEL;
      end else begin
         act = ACT_UNUSED;
      end
      entry = $urandom_range(KEY_POOL - 1);
      k     = pool_key[entry];
      h     = pool_hash[entry];
      pick  = $urandom_range(99);
      if (pick < 4) begin
         k = $urandom;
         h = $urandom;
      end else if (pick < 7) begin
         h = $urandom;
      end
      send_request(act, k, h, {$urandom, $urandom}, idle_pct);
   endtask

   // Random requests, then a pause until every response is in.
   task automatic run_phase(int unsigned count, int unsigned idle_pct);
      for (int i = 0; i < count; i++) begin
         random_request(idle_pct);
      end
      start <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0] low;
      // Hashes fall in two tight clusters or at random; one cluster is at the top
      // of the table so that probe runs wrap round to slot zero.
      foreach (pool_key[i]) begin
         pool_key[i] = $urandom;
         case ($urandom_range(2))
            0:       low = 8'hFC + 8'($urandom_range(3));
            1:       low = 8'h40 + 8'($urandom_range(3));
            default: low = 8'($urandom);
         endcase
         pool_hash[i] = {24'($urandom), low};
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty table: get, delete and the undefined action all miss.
      send_request(ACT_GET, 32'h0, 32'h0, 64'h0, 0);
      send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 0);
      send_request(ACT_UNUSED, 32'h1234_5678, 32'h0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      // Two keys on the top slot: the second wraps round to slot zero.
      send_request(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7);
      send_request(ACT_SET, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_GET, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 7);
      send_request(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 7);
      send_request(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 7);
      send_request(ACT_GET, 32'h0000_0077, 32'h0000_00FF, 64'h0, 7);
      // Deletion leaves a tombstone that later probes must step over.
      send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 7);
      send_request(ACT_GET, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 7);
      send_request(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 7);
      // A new key takes the tombstone rather than the empty slot further on.
      send_request(ACT_SET, 32'h0000_0005, 32'hFFFF_FFFF, 64'hA5A5_5A5A_F00D_0001, 7);
      send_request(ACT_SET, 32'h0, 32'h0000_00FF, 64'h8000_0000_0000_0001, 7);
      send_request(ACT_UNUSED, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_GET, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_DEL, 32'h0, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_SET, 32'h0, 32'h0000_00FF, 64'h7FFF_FFFF_FFFF_FFFE, 7);
      send_request(ACT_GET, 32'h0000_0005, 32'h0000_00FF, 64'h0, 7);
      send_request(ACT_GET, 32'h0, 32'h0000_00FF, 64'h0, 7);

      run_phase(560, 7);
      run_phase(560, 59);
      run_phase(540, 0);

      // Fill with fresh keys up to the load limit, after which sets are refused.
      while (4 * (shadow.used + 1) <= 3 * SLOTS) begin
         send_request(ACT_SET, $urandom, $urandom, {$urandom, $urandom}, 0);
      end
      send_request(ACT_SET, $urandom, $urandom, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_request(ACT_SET, pool_key[0], pool_hash[0], 64'h0, 0);
      run_phase(40, 0);

      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
